// ===== rtl/core/generational_handle_pool_unit_macros.svh =====
// Assertion macros shared by the generational handle pool RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef GENERATIONAL_HANDLE_POOL_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_POOL_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ghp_pkg.sv =====
// Shared types and constants for the generational handle pool.
// No dependencies; imported by ghp_alloc, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package ghp_pkg;

  localparam int unsigned CmdW        = 2;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned HandleIdxW  = 8;
  localparam int unsigned GenW        = 16;
  localparam int unsigned PayloadW    = 32;
  localparam int unsigned DataW       = 56;
  localparam int unsigned SlotCountDef   = 64;
  localparam int unsigned PayloadBitsDef = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_GET     = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_HANDLE = 2'd2,
    ST_STALE      = 2'd3
  } status_e;

  // Lowest free slot as seen by the allocator
  typedef struct packed {
    logic                  full;
    logic [HandleIdxW-1:0] idx;
  } alloc_t;

endpackage

`default_nettype wire

// ===== rtl/core/ghp_slot_mem.sv =====
// Slot memory: one row per slot holding {generation, payload}.
// Synchronous, one write port and one read port, read data registered.
`timescale 1ns / 1ps
`default_nettype none

module ghp_slot_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/ghp_alloc.sv =====
// Allocator: priority encoder that finds the lowest free slot.
// Depends on ghp_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module ghp_alloc #(
  parameter int unsigned SlotCount = 64
) (
  input  wire logic [SlotCount-1:0] alive_i,
  output ghp_pkg::alloc_t           alloc_o
);
  import ghp_pkg::*;

  always_comb begin
    alloc_o.full = &alive_i;
    alloc_o.idx  = '0;
    // scan from the top so the lowest free slot wins
    for (int i = int'(SlotCount) - 1; i >= 0; i--) begin
      if (!alive_i[i]) begin
        alloc_o.idx = HandleIdxW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/generational_handle_pool_unit.sv =====
// Generational handle pool: top level with control, live bits and output stage.
// Depends on ghp_pkg, ghp_alloc, ghp_slot_mem and the assertion macro header.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the command
//   (create, destroy, get), tdata the handle index, handle generation and
//   payload word. Each request yields exactly one result on m_axis: tuser
//   carries the status, tdata the allocated index, its generation and the
//   payload returned by get.
//   One request is in flight at a time. The accept cycle looks up the
//   lowest free slot and issues the slot memory read; the execute state then
//   checks the handle and, once the output register is free, writes the
//   memory and loads the output register. A new request is taken only after
//   the previous one completes, as the slot memory is read, then written.
//   A waiting result does not block the next request; only its completion
//   waits while the output register is still held by a stalled receiver.
//   Reset clears every live bit and every written bit, so every generation reads
//   as zero; the payload memory is not cleared and is only returned for live slots.
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_pool_unit #(
  parameter int unsigned SLOT_COUNT   = ghp_pkg::SlotCountDef,
  parameter int unsigned PAYLOAD_BITS = ghp_pkg::PayloadBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [7:0] handle_index, [23:8] handle_generation, [55:24] payload_in
  input  wire logic [ghp_pkg::DataW-1:0]    s_axis_tdata_i,
  // [1:0] cmd
  input  wire logic [ghp_pkg::CmdW-1:0]     s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // [7:0] slot_index, [23:8] slot_generation, [55:24] payload_out
  output logic      [ghp_pkg::DataW-1:0]    m_axis_tdata_o,
  // [1:0] status
  output logic      [ghp_pkg::StatusW-1:0]  m_axis_tuser_o
);
  import ghp_pkg::*;

`include "generational_handle_pool_unit_macros.svh"

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);
  localparam int unsigned RowW = GenW + PAYLOAD_BITS;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [CmdW-1:0]         cmd_q;
  logic [GenW-1:0]         hgen_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [IdxW-1:0]         addr_q, addr_d;
  logic                    full_q;
  logic                    range_ok_q;

  logic [SLOT_COUNT-1:0]   alive_q;
  logic [SLOT_COUNT-1:0]   written_q;

  logic                    out_valid_q;
  status_e                 status_q, status_d;
  logic [HandleIdxW-1:0]   oidx_q, oidx_d;
  logic [GenW-1:0]         ogen_q, ogen_d;
  logic [PayloadW-1:0]     opay_q, opay_d;

  alloc_t                  alloc;
  logic                    accept;
  logic                    advance;
  logic [RowW-1:0]         rd_row;
  logic [RowW-1:0]         wr_row;
  logic [GenW-1:0]         stored_gen;
  logic [GenW-1:0]         next_gen;
  logic                    slot_live;
  logic                    mem_we;
  logic                    kill;

  logic [HandleIdxW-1:0]   in_idx;
  logic [GenW-1:0]         in_gen;
  logic [PayloadW-1:0]     in_pay;

  assign in_idx = s_axis_tdata_i[HandleIdxW-1:0];
  assign in_gen = s_axis_tdata_i[HandleIdxW+GenW-1:HandleIdxW];
  assign in_pay = s_axis_tdata_i[HandleIdxW+GenW+PayloadW-1:HandleIdxW+GenW];

  ghp_alloc #(
    .SlotCount(SLOT_COUNT)
  ) u_alloc (
    .alive_i(alive_q),
    .alloc_o(alloc)
  );

  ghp_slot_mem #(
    .Depth(SLOT_COUNT),
    .Width(RowW)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (accept),
    .rd_addr_i(addr_d),
    .rd_data_o(rd_row),
    .we_i     (mem_we),
    .wr_addr_i(addr_q),
    .wr_data_i(wr_row)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign advance         = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready_i);

  // Create takes the allocator's slot, destroy and get the handle's index
  assign addr_d = (s_axis_tuser_i == CMD_CREATE) ? alloc.idx[IdxW-1:0]
                                                 : in_idx[IdxW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (advance) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Generation reads as zero until the slot has been created once
  assign stored_gen = written_q[addr_q] ? rd_row[RowW-1:PAYLOAD_BITS] : '0;
  assign slot_live  = alive_q[addr_q];
  assign next_gen   = ((stored_gen + GenW'(1)) == '0) ? GenW'(1) : stored_gen + GenW'(1);
  assign wr_row     = {next_gen, pay_q};

  always_comb begin
    status_d = ST_BAD_HANDLE;
    oidx_d   = '0;
    ogen_d   = '0;
    opay_d   = '0;
    mem_we   = 1'b0;
    kill     = 1'b0;
    case (cmd_q) inside
      CMD_CREATE: begin
        if (full_q) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
          oidx_d   = HandleIdxW'(addr_q);
          ogen_d   = next_gen;
          mem_we   = advance;
        end
      end
      CMD_DESTROY, CMD_GET: begin
        if (hgen_q == '0 || !range_ok_q) begin
          status_d = ST_BAD_HANDLE;
        end else if (!slot_live || stored_gen != hgen_q) begin
          status_d = ST_STALE;
        end else begin
          status_d = ST_OK;
          if (cmd_q == CMD_GET) begin
            opay_d = PayloadW'(rd_row[PAYLOAD_BITS-1:0]);
          end else begin
            kill = advance;
          end
        end
      end
      default: status_d = ST_BAD_HANDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      alive_q     <= '0;
      written_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        alive_q[addr_q]   <= 1'b1;
        written_q[addr_q] <= 1'b1;
      end
      if (kill) begin
        alive_q[addr_q] <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request fields and result payload carry no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= s_axis_tuser_i;
      hgen_q     <= in_gen;
      pay_q      <= PAYLOAD_BITS'(in_pay);
      addr_q     <= addr_d;
      full_q     <= alloc.full;
      range_ok_q <= ({1'b0, in_idx} < (HandleIdxW + 1)'(SLOT_COUNT));
    end
    if (advance) begin
      status_q <= status_d;
      oidx_q   <= oidx_d;
      ogen_q   <= ogen_d;
      opay_q   <= opay_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {opay_q, ogen_q, oidx_q};

  `GHP_ASSERT_NEXT(a_accept_to_exec, accept, state_q == S_EXEC && !s_axis_tready_o,
                   "accepted item did not enter the execute cycle")
  `GHP_ASSERT_NOW(a_create_gen_nonzero,
                  advance && cmd_q == CMD_CREATE && status_d == ST_OK, ogen_d != '0,
                  "successful create produced generation zero")
  `GHP_ASSERT_NEXT(a_create_marks_live, mem_we, alive_q[$past(addr_q)] && written_q[$past(addr_q)],
                   "created slot not marked live")
  `GHP_ASSERT_NOW(a_one_update, mem_we || kill, advance && !(mem_we && kill),
                  "slot state changed outside a completing item")

endmodule

`default_nettype wire

// ===== test/tb_generational_handle_pool_unit.sv =====
// Self-checking testbench for generational_handle_pool_unit: stream handshakes on both sides,
// with a slot-pool scoreboard that predicts every result. Depends on ghp_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_generational_handle_pool_unit;
  import ghp_pkg::*;

  localparam int SLOTS = ghp_pkg::SlotCountDef;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int END_PAUSE = 8;
  localparam int PHASE_ITEMS = 540;
  localparam int RECYCLE_ROUNDS = 8;

  typedef struct packed {
    status_e              status;
    logic [HandleIdxW-1:0] idx;
    logic [GenW-1:0]       gen;
    logic [PayloadW-1:0]   word;
  } pool_result_t;

  class handle_pool_scoreboard;
    pool_result_t   expected_q[$];
    bit             slot_live[SLOTS];
    logic [GenW-1:0] slot_gen[SLOTS];
    logic [PayloadW-1:0] slot_word[SLOTS];
    int             mismatches;
    int             last_idx;
    logic [GenW-1:0] last_gen;

    function new();
      foreach (slot_gen[i]) begin
        slot_live[i] = 1'b0;
        slot_gen[i]  = '0;
        slot_word[i] = '0;
      end
      mismatches  = 0;
    endfunction

    // Apply one accepted request to the pool and queue the result it must produce
    function void note_request(logic [CmdW-1:0] cmd, logic [HandleIdxW-1:0] idx,
                               logic [GenW-1:0] gen, logic [PayloadW-1:0] word);
      pool_result_t res;
      bit found;
      res = '{ST_BAD_HANDLE, '0, '0, '0};
      found = 1'b0;
      case (cmd)
        CMD_CREATE: begin
          res.status = ST_FULL;
          for (int s = 0; s < SLOTS && !found; s++) begin
            if (!slot_live[s]) begin
              found = 1'b1;
              slot_gen[s] = slot_gen[s] + 16'd1;
              if (slot_gen[s] == '0) begin
                slot_gen[s] = 16'd1;
              end
              slot_word[s] = word;
              slot_live[s] = 1'b1;
              res.status = ST_OK;
              res.idx = HandleIdxW'(s);
              res.gen = slot_gen[s];
              last_idx = s;
              last_gen = slot_gen[s];
            end
          end
        end
        CMD_DESTROY, CMD_GET: begin
          if (gen == '0 || idx >= SLOTS) begin
            res.status = ST_BAD_HANDLE;
          end else if (!slot_live[idx] || slot_gen[idx] != gen) begin
            res.status = ST_STALE;
          end else begin
            res.status = ST_OK;
            if (cmd == CMD_GET) begin
              res.word = slot_word[idx];
            end else begin
              slot_live[idx] = 1'b0;
              slot_word[idx] = '0;
            end
          end
        end
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [StatusW-1:0] status, logic [DataW-1:0] data);
      pool_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request pending: status %0d data %h",
                   $realtime, status, data);
        return;
      end
      want = expected_q.pop_front();
      if (status !== want.status || data[7:0] !== want.idx || data[23:8] !== want.gen ||
          data[55:24] !== want.word) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch: expected status %0d idx %0d gen %0d payload %h, ",
                    "got status %0d idx %0d gen %0d payload %h"}, $realtime,
                   want.status, want.idx, want.gen, want.word,
                   status, data[7:0], data[23:8], data[55:24]);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  // [7:0] handle_index, [23:8] handle_generation, [55:24] payload_in
  logic [DataW-1:0]    s_axis_tdata_i;
  // [1:0] cmd
  logic [CmdW-1:0]     s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  // [7:0] slot_index, [23:8] slot_generation, [55:24] payload_out
  logic [DataW-1:0]    m_axis_tdata_o;
  // [1:0] status
  logic [StatusW-1:0]  m_axis_tuser_o;

  handle_pool_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold;
  int quiet_cycles;

  generational_handle_pool_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side: check every accepted item, then pick next cycle's ready
  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tuser_o, m_axis_tdata_o);
      if (recv_hold > 0) begin
        recv_hold--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // End the run when neither side moves an item for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
          (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [PayloadW-1:0] payload_word();
    if ($urandom_range(9) == 0)
      return $urandom_range(1) ? '1 : '0;
    return $urandom;
  endfunction

  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [HandleIdxW-1:0] idx,
                           input logic [GenW-1:0] gen, input logic [PayloadW-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {word, gen, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(cmd, idx, gen, word);
  endtask

  // Pause the input until every outstanding result has come back
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Creates at the given percentage; otherwise mostly requests against live handles, the rest stale, dead or malformed
  task automatic send_random(input int create_pct, output bit counted);
    logic [CmdW-1:0]       cmd;
    logic [HandleIdxW-1:0] idx;
    logic [GenW-1:0]       gen;
    int r;
    int s;
    int live_q[$];
    idx = HandleIdxW'($urandom_range(255));
    gen = GenW'($urandom_range(65535));
    counted = 1'b1;
    foreach (sb.slot_live[k])
      if (sb.slot_live[k]) live_q.push_back(k);
    if ($urandom_range(99) < create_pct) begin
      cmd = CMD_CREATE;
    end else begin
      cmd = $urandom_range(1) ? CMD_GET : CMD_DESTROY;
      r = $urandom_range(99);
      if (r < 65 && live_q.size() > 0) begin
        s = live_q[$urandom_range(live_q.size() - 1)];
        idx = HandleIdxW'(s);
        gen = sb.slot_gen[s];
      end else if (r < 80) begin
        // dead slot with its last generation, or live slot with a wrong one
        s = $urandom_range(SLOTS - 1);
        idx = HandleIdxW'(s);
        gen = sb.slot_gen[s];
        if (sb.slot_live[s]) gen = gen ^ (16'd1 << $urandom_range(15));
      end else if (r < 90) begin
        gen = '0;
      end else if (r < 96) begin
        idx = HandleIdxW'($urandom_range(255, SLOTS));
      end else begin
        cmd = CMD_UNUSED;
        counted = 1'b0;
      end
    end
    send_item(cmd, idx, gen, payload_word());
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct,
                                  input bit with_hold_off);
    int sent;
    bit counted;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if (with_hold_off && sent == PHASE_ITEMS / 3) recv_hold = HOLD_OFF_CYCLES;
      // alternate fill-heavy and drain-heavy stretches so the pool runs full and empty
      send_random(((sent / 80) % 2 == 0) ? 85 : 25, counted);
      if (counted) sent++;
    end
    drain();
  endtask

  // Recycle the lowest free slot a few times: create, read back on even rounds, destroy
  task automatic run_slot_recycle();
    int rounds;
    bit full;
    logic [HandleIdxW-1:0] idx;
    logic [GenW-1:0] gen;
    full = 1'b1;
    foreach (sb.slot_live[k])
      if (!sb.slot_live[k]) full = 1'b0;
    if (full) send_item(CMD_DESTROY, HandleIdxW'(SLOTS - 1), sb.slot_gen[SLOTS - 1], '0);
    for (rounds = 0; rounds < RECYCLE_ROUNDS; rounds++) begin
      send_item(CMD_CREATE, HandleIdxW'($urandom_range(255)), GenW'($urandom_range(65535)),
                payload_word());
      idx = HandleIdxW'(sb.last_idx);
      gen = sb.last_gen;
      if (rounds % 2 == 0)
        send_item(CMD_GET, idx, gen, $urandom);
      send_item(CMD_DESTROY, idx, gen, $urandom);
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 9;
    recv_idle_pct = 68;
    recv_hold = 0;
    rst_ni <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    s_axis_tuser_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: handle checks on an empty pool, then create, get and destroy by hand
    send_item(CMD_GET, 8'd0, 16'd0, 32'd0);
    send_item(CMD_DESTROY, 8'd0, 16'd1, 32'd0);
    send_item(CMD_GET, 8'd63, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_CREATE, 8'd0, 16'd0, 32'h0000_0000);
    send_item(CMD_CREATE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_GET, 8'd0, 16'd1, 32'd0);
    send_item(CMD_GET, 8'd1, 16'd1, 32'd0);
    send_item(CMD_GET, 8'd1, 16'd2, 32'd0);
    send_item(CMD_GET, 8'd64, 16'd1, 32'd0);
    send_item(CMD_DESTROY, 8'd255, 16'hFFFF, 32'd0);
    send_item(CMD_DESTROY, 8'd0, 16'd0, 32'd0);
    send_item(CMD_UNUSED, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_DESTROY, 8'd0, 16'd1, 32'd0);
    send_item(CMD_GET, 8'd0, 16'd1, 32'd0);
    send_item(CMD_DESTROY, 8'd0, 16'd1, 32'd0);
    send_item(CMD_CREATE, 8'd0, 16'd0, 32'hA5A5_A5A5);
    send_item(CMD_GET, 8'd0, 16'd2, 32'd0);
    send_item(CMD_CREATE, 8'd0, 16'd0, 32'h5A5A_5A5A);
    send_item(CMD_GET, 8'd2, 16'd1, 32'd0);
    send_item(CMD_DESTROY, 8'd1, 16'd1, 32'd0);
    send_item(CMD_DESTROY, 8'd0, 16'd2, 32'd0);
    send_item(CMD_DESTROY, 8'd2, 16'd1, 32'd0);
    drain();

    run_random_phase(9, 68, 1'b1);
    run_random_phase(68, 9, 1'b0);
    run_random_phase(0, 0, 1'b1);
    run_slot_recycle();
    drain();
    repeat (END_PAUSE) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
